[rtl/core/kvi_pkg.sv]
// Shared types, constants and helpers of the keyframe vec3 interpolator.
// Used by every module under rtl/core; depends on nothing else.
package kvi_pkg;

   localparam int MAX_KEYS   = 256;
   localparam int KEY_AW     = $clog2(MAX_KEYS);
   localparam int CNT_W      = KEY_AW + 1;
   localparam int VALUE_BITS = 32;
   localparam int DATA_W     = 32;
   localparam int COMP_N     = 3;
   localparam int MUL_W      = 34;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ACC_W      = 72;
   localparam int H_W        = 20;
   localparam int M_W        = 50;
   localparam int ALPHA_W    = 17;
   localparam int DT_W       = 33;
   localparam int CSR_IDX_W  = 3;

   localparam logic [1:0] MODE_STEP   = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_CUBIC  = 2'd2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_Z      = 3'd4;

   localparam logic signed [ACC_W-1:0] SAT_HI =
      (ACC_W'(1) <<< (VALUE_BITS - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   typedef struct packed {
      logic [COMP_N-1:0][DATA_W-1:0] out_tan;
      logic [COMP_N-1:0][DATA_W-1:0] val;
      logic [COMP_N-1:0][DATA_W-1:0] in_tan;
   } kvi_entry_type;

   typedef struct packed {
      logic       start;
      logic [1:0] mode;
      logic       same;
   } kvi_blend_ctl_type;

   function automatic logic [DATA_W-1:0] sat_value(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] c;
      c = v;
      if (v > SAT_HI) c = SAT_HI;
      else if (v < SAT_LO) c = SAT_LO;
      return c[DATA_W-1:0];
   endfunction

endpackage

[rtl/core/keyframe_vec3_interpolator_core.sv]
// Top level of the keyframe vec3 interpolator: request/response streams,
// register port, search sequencer. Depends on kvi_pkg, kvi_key_mem, kvi_div
// and kvi_blend.
//
// Usage:
//  - req_*: a request with tuser 0 writes one keyframe entry (slot, time,
//    in-tangent, value, out-tangent) and gives no response.
//    A request with tuser 1 queries the track at tdata time and gives one
//    response on rsp_* (x, y, z; tuser set when the table was empty).
//  - csr_*: register writes (mode, key count, fallback x/y/z), always ready;
//    write them only while no query is in flight.
//  - A query on an empty table goes straight to the output register. A clamped
//    or single-key query clamps, fetches the entries, blends and outputs. A
//    searched query first runs the binary search (up to 9 steps over 256 keys)
//    and, when the query time falls strictly inside the pair, the blend-factor
//    divider. A bracketing pair is blended by step, linear or cubic, the shared
//    34x34 multiplier being stepped through 26 products for cubic. One query is
//    worked at a time.
//  - The response waits in an output register; the next request is taken while
//    it waits, and a new query stalls only at its end until that slot frees.
//  - Reset clears the registers to mode linear, an empty table and zero
//    fallback; the key memories are not cleared and hold garbage until written.
module keyframe_vec3_interpolator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // key_slot[7:0], time_point[39:8], in_tan_x/y/z[135:40], val_x/y/z[231:136],
   // out_tan_x/y/z[327:232]
   input  logic [327:0]                       req_tdata,
   // func
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // res_x[31:0], res_y[63:32], res_z[95:64]
   output logic [95:0]                        rsp_tdata,
   // used_fallback
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kvi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kvi_pkg::DATA_W-1:0]         csr_data
);
   import kvi_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_T0, S_TL, S_SRCH_RD, S_SRCH_CMP, S_LO_RD, S_HI_RD, S_ALPHA,
      S_DIV, S_E0, S_E1, S_E2, S_BSTART, S_BLEND, S_OUT
   } state_type;

   state_type            state_ff;
   logic [1:0]           mode_ff;
   logic [CNT_W-1:0]     key_count_ff;
   logic [DATA_W-1:0]    fb_x_ff, fb_y_ff, fb_z_ff;
   logic [CNT_W-1:0]     n_ff, first_ff, len_ff;
   logic [CNT_W-1:0]     lo_ff, hi_ff;
   logic [DATA_W-1:0]    tq_ff, t0_ff, tlo_ff;
   logic [DT_W-1:0]      dt_ff;
   logic [ALPHA_W-1:0]   alpha_ff;
   logic                 fb_ff;
   logic                 rsp_valid_ff;
   logic [95:0]          rsp_data_ff;
   logic                 rsp_user_ff;
   kvi_entry_type        ent_lo_ff, ent_hi_ff;

   logic                 req_acc;
   logic                 wr_en;
   kvi_entry_type        wr_entry;
   logic [KEY_AW-1:0]    time_rd_addr, ent_rd_addr;
   logic [DATA_W-1:0]    time_rd_data;
   kvi_entry_type        ent_rd_data;
   logic [CNT_W-1:0]     n_in, half, hi_c, n_m1;
   logic [DATA_W-1:0]    diff;
   logic                 div_start, div_done;
   logic [15:0]          div_quot;
   kvi_blend_ctl_type    bctl;
   logic                 blend_done;
   logic [COMP_N-1:0][DATA_W-1:0] blend_res;
   logic                 out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign wr_en      = req_acc && (req_tuser == FUNC_WRITE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      for (int c = 0; c < COMP_N; c++) begin
         wr_entry.in_tan[c]  = req_tdata[40 + 32 * c +: DATA_W];
         wr_entry.val[c]     = req_tdata[136 + 32 * c +: DATA_W];
         wr_entry.out_tan[c] = req_tdata[232 + 32 * c +: DATA_W];
      end
      n_in = (key_count_ff > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : key_count_ff;
      n_m1 = n_ff - CNT_W'(1);
      half = len_ff >> 1;
      hi_c = first_ff;
      if (hi_c < CNT_W'(1)) hi_c = CNT_W'(1);
      if (hi_c > n_m1) hi_c = n_m1;
      diff = tq_ff - tlo_ff;
      unique case (state_ff)
         S_T0:      time_rd_addr = n_m1[KEY_AW-1:0];
         S_SRCH_RD: time_rd_addr = KEY_AW'(first_ff + half);
         S_LO_RD:   time_rd_addr = lo_ff[KEY_AW-1:0];
         S_HI_RD:   time_rd_addr = hi_ff[KEY_AW-1:0];
         default:   time_rd_addr = '0;
      endcase
      ent_rd_addr = (state_ff == S_E1) ? hi_ff[KEY_AW-1:0] : lo_ff[KEY_AW-1:0];
      div_start   = (state_ff == S_ALPHA) && (time_rd_data > tlo_ff) &&
                    (tq_ff > tlo_ff) &&
                    ({1'b0, diff} < ({1'b0, time_rd_data} - {1'b0, tlo_ff}));
      bctl.start  = (state_ff == S_BSTART);
      bctl.mode   = mode_ff;
      bctl.same   = (lo_ff == hi_ff);
   end

   kvi_key_mem u_mem (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (req_tdata[KEY_AW-1:0]),
      .wr_time      (req_tdata[39:8]),
      .wr_entry     (wr_entry),
      .time_rd_addr (time_rd_addr),
      .time_rd_data (time_rd_data),
      .ent_rd_addr  (ent_rd_addr),
      .ent_rd_data  (ent_rd_data)
   );

   kvi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .diff  (diff),
      .dt    (dt_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   kvi_blend u_blend (
      .clock  (clock),
      .reset  (reset),
      .ctl    (bctl),
      .alpha  (alpha_ff),
      .dt     (dt_ff),
      .ent_lo (ent_lo_ff),
      .ent_hi (ent_hi_ff),
      .done   (blend_done),
      .res    (blend_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_LINEAR;
         key_count_ff <= '0;
         fb_x_ff      <= '0;
         fb_y_ff      <= '0;
         fb_z_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MODE:      mode_ff      <= csr_data[1:0];
               CSR_KEY_COUNT: key_count_ff <= csr_data[CNT_W-1:0];
               CSR_FB_X:      fb_x_ff      <= csr_data;
               CSR_FB_Y:      fb_y_ff      <= csr_data;
               CSR_FB_Z:      fb_z_ff      <= csr_data;
               default: ;
            endcase
         end
         // A free slot refilled in the output state stays valid.
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_acc && req_tuser == FUNC_QUERY) begin
                  tq_ff    <= req_tdata[39:8];
                  n_ff     <= n_in;
                  alpha_ff <= '0;
                  dt_ff    <= '0;
                  fb_ff    <= (n_in == '0);
                  state_ff <= (n_in == '0) ? S_OUT : S_T0;
               end
            end
            S_T0: begin
               t0_ff    <= time_rd_data;
               state_ff <= S_TL;
            end
            S_TL: begin
               if (n_ff == CNT_W'(1) || tq_ff <= t0_ff) begin
                  lo_ff    <= '0;
                  hi_ff    <= '0;
                  state_ff <= S_E0;
               end else if (tq_ff >= time_rd_data) begin
                  lo_ff    <= n_m1;
                  hi_ff    <= n_m1;
                  state_ff <= S_E0;
               end else begin
                  first_ff <= '0;
                  len_ff   <= n_ff;
                  state_ff <= S_SRCH_RD;
               end
            end
            S_SRCH_RD: begin
               if (len_ff == '0) begin
                  hi_ff    <= hi_c;
                  lo_ff    <= hi_c - CNT_W'(1);
                  state_ff <= S_LO_RD;
               end else begin
                  state_ff <= S_SRCH_CMP;
               end
            end
            S_SRCH_CMP: begin
               // Lower-bound step: skip past the probe when its time is smaller.
               if (time_rd_data < tq_ff) begin
                  first_ff <= first_ff + half + CNT_W'(1);
                  len_ff   <= len_ff - half - CNT_W'(1);
               end else begin
                  len_ff   <= half;
               end
               state_ff <= S_SRCH_RD;
            end
            S_LO_RD: state_ff <= S_HI_RD;
            S_HI_RD: begin
               tlo_ff   <= time_rd_data;
               state_ff <= S_ALPHA;
            end
            S_ALPHA: begin
               state_ff <= S_E0;
               if (time_rd_data > tlo_ff) begin
                  dt_ff <= {1'b0, time_rd_data} - {1'b0, tlo_ff};
                  if (div_start) state_ff <= S_DIV;
                  else if (tq_ff > tlo_ff) alpha_ff <= ALPHA_W'(65536);
               end
            end
            S_DIV: begin
               if (div_done) begin
                  alpha_ff <= {1'b0, div_quot};
                  state_ff <= S_E0;
               end
            end
            S_E0: state_ff <= S_E1;
            S_E1: begin
               ent_lo_ff <= ent_rd_data;
               state_ff  <= S_E2;
            end
            S_E2: begin
               ent_hi_ff <= ent_rd_data;
               state_ff  <= S_BSTART;
            end
            S_BSTART: state_ff <= S_BLEND;
            S_BLEND: begin
               if (blend_done) state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= fb_ff;
                  rsp_data_ff  <= fb_ff ? {fb_z_ff, fb_y_ff, fb_x_ff}
                                        : {blend_res[2], blend_res[1], blend_res[0]};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_blend_done_in_blend: assert property (@(posedge clock) disable iff (reset)
      blend_done |-> state_ff == S_BLEND)
      else $error("blend finished outside the blend wait");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide wait");

   a_pair_adjacent: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_E0 |-> (hi_ff == lo_ff || hi_ff == lo_ff + CNT_W'(1)))
      else $error("bracketing pair is not adjacent");

   a_pair_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_E0 |-> hi_ff < n_ff)
      else $error("bracketing key beyond the key count");

endmodule

[rtl/core/kvi_key_mem.sv]
// Keyframe storage: a time memory and an entry memory (tangents and value).
// Both have one write and one registered read port. Depends on kvi_pkg.
module kvi_key_mem (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [kvi_pkg::KEY_AW-1:0]    wr_addr,
   input  logic [kvi_pkg::DATA_W-1:0]    wr_time,
   input  kvi_pkg::kvi_entry_type        wr_entry,
   input  logic [kvi_pkg::KEY_AW-1:0]    time_rd_addr,
   output logic [kvi_pkg::DATA_W-1:0]    time_rd_data,
   input  logic [kvi_pkg::KEY_AW-1:0]    ent_rd_addr,
   output kvi_pkg::kvi_entry_type        ent_rd_data
);
   import kvi_pkg::*;

   logic [DATA_W-1:0] time_mem [MAX_KEYS];
   kvi_entry_type     ent_mem  [MAX_KEYS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_time;
         ent_mem[wr_addr]  <= wr_entry;
      end
      time_rd_data <= time_mem[time_rd_addr];
      ent_rd_data  <= ent_mem[ent_rd_addr];
   end

endmodule

[rtl/core/kvi_div.sv]
// Restoring divider for the blend factor: floor(diff * 2^16 / dt), diff < dt.
// One quotient bit per cycle, 16 bits in all. Depends on kvi_pkg.
module kvi_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [kvi_pkg::DATA_W-1:0]  diff,
   input  logic [kvi_pkg::DT_W-1:0]    dt,
   output logic                        done,
   output logic [15:0]                 quot
);
   import kvi_pkg::*;

   logic              run_ff;
   logic              done_ff;
   logic [3:0]        cnt_ff;
   logic [DT_W:0]     rem_ff;
   logic [15:0]       q_ff;
   logic [DT_W:0]     rem2;
   logic              fits;

   always_comb begin
      rem2 = {rem_ff[DT_W-1:0], 1'b0};
      fits = rem2 >= {1'b0, dt};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= {2'b00, diff};
         end else if (run_ff) begin
            rem_ff <= fits ? rem2 - {1'b0, dt} : rem2;
            q_ff   <= {q_ff[14:0], fits};
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

[rtl/core/kvi_blend.sv]
// Blend unit: step, linear and cubic Hermite on the bracketing entry pair,
// sequenced through one shared 34x34 multiplier. Depends on kvi_pkg.
module kvi_blend (
   input  logic                                      clock,
   input  logic                                      reset,
   input  kvi_pkg::kvi_blend_ctl_type                ctl,
   input  logic [kvi_pkg::ALPHA_W-1:0]               alpha,
   input  logic [kvi_pkg::DT_W-1:0]                  dt,
   input  kvi_pkg::kvi_entry_type                    ent_lo,
   input  kvi_pkg::kvi_entry_type                    ent_hi,
   output logic                                      done,
   output logic [kvi_pkg::COMP_N-1:0][kvi_pkg::DATA_W-1:0] res
);
   import kvi_pkg::*;

   typedef enum logic [1:0] {B_IDLE, B_SETUP, B_CUBIC, B_LINEAR} bstate_type;

   bstate_type                   state_ff;
   logic [2:0]                   op_ff;
   logic [1:0]                   comp_ff;
   logic                         phase_ff;
   logic                         done_ff;
   logic [COMP_N-1:0][DATA_W-1:0] res_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic [ALPHA_W-1:0]           s2_ff;
   logic [ALPHA_W-1:0]           s3_ff;
   logic signed [M_W-1:0]        m0_ff;
   logic signed [M_W-1:0]        m1_ff;
   logic signed [ACC_W-1:0]      acc_ff;

   logic signed [H_W-1:0]        h00, h10, h01, h11;
   logic signed [H_W-1:0]        sx, s2x, s3x;
   logic signed [MUL_W-1:0]      mul_a, mul_b;
   logic signed [ACC_W-1:0]      prod72, term, acc_sum, lin_sum;
   logic [DATA_W-1:0]            v_lo, v_hi;
   logic signed [DATA_W:0]       vdiff;

   always_comb begin
      sx  = $signed({3'b000, alpha});
      s2x = $signed({3'b000, s2_ff});
      s3x = $signed({3'b000, s3_ff});
      h00 = H_W'(2 * s3x - 3 * s2x + 65536);
      h10 = H_W'(s3x - 2 * s2x + sx);
      h01 = H_W'(3 * s2x - 2 * s3x);
      h11 = H_W'(s3x - s2x);
      v_lo  = ent_lo.val[comp_ff];
      v_hi  = ent_hi.val[comp_ff];
      vdiff = $signed({v_hi[DATA_W-1], v_hi}) - $signed({v_lo[DATA_W-1], v_lo});
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         B_SETUP: begin
            mul_a = $signed({17'b0, (op_ff[0] ? s2_ff : alpha)});
            mul_b = $signed({17'b0, alpha});
         end
         B_LINEAR: begin
            mul_a = $signed({vdiff[DATA_W], vdiff});
            mul_b = $signed({17'b0, alpha});
         end
         B_CUBIC: begin
            unique case (op_ff)
               3'd0: begin
                  mul_a = $signed({{2{ent_lo.out_tan[comp_ff][DATA_W-1]}},
                                   ent_lo.out_tan[comp_ff]});
                  mul_b = $signed({1'b0, dt});
               end
               3'd1: begin
                  mul_a = $signed({{2{ent_hi.in_tan[comp_ff][DATA_W-1]}},
                                   ent_hi.in_tan[comp_ff]});
                  mul_b = $signed({1'b0, dt});
               end
               3'd2: begin
                  mul_a = $signed({{14{h00[H_W-1]}}, h00});
                  mul_b = $signed({{2{v_lo[DATA_W-1]}}, v_lo});
               end
               3'd3: begin
                  mul_a = $signed({{14{h01[H_W-1]}}, h01});
                  mul_b = $signed({{2{v_hi[DATA_W-1]}}, v_hi});
               end
               3'd4: begin
                  mul_a = $signed({{14{h10[H_W-1]}}, h10});
                  mul_b = $signed({10'b0, m0_ff[23:0]});
               end
               3'd5: begin
                  mul_a = $signed({{14{h10[H_W-1]}}, h10});
                  mul_b = $signed({{8{m0_ff[M_W-1]}}, m0_ff[M_W-1:24]});
               end
               3'd6: begin
                  mul_a = $signed({{14{h11[H_W-1]}}, h11});
                  mul_b = $signed({10'b0, m1_ff[23:0]});
               end
               default: begin
                  mul_a = $signed({{14{h11[H_W-1]}}, h11});
                  mul_b = $signed({{8{m1_ff[M_W-1]}}, m1_ff[M_W-1:24]});
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod72  = $signed({{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
      term    = (op_ff == 3'd5 || op_ff == 3'd7) ? (prod72 <<< 24) : prod72;
      acc_sum = ((op_ff == 3'd2) ? '0 : acc_ff) + term;
      lin_sum = $signed({{(ACC_W-DATA_W){v_lo[DATA_W-1]}}, v_lo}) + (prod72 >>> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         op_ff    <= '0;
         comp_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (state_ff != B_IDLE) phase_ff <= ~phase_ff;
         if (state_ff != B_IDLE && !phase_ff) prod_ff <= mul_a * mul_b;
         unique case (state_ff)
            B_IDLE: begin
               phase_ff <= 1'b0;
               op_ff    <= '0;
               comp_ff  <= '0;
               if (ctl.start) begin
                  if (ctl.mode == MODE_STEP || ctl.same) begin
                     // Step takes the upper key only once alpha reaches 1.0.
                     for (int c = 0; c < COMP_N; c++) begin
                        res_ff[c] <= (ctl.mode == MODE_STEP && alpha[ALPHA_W-1])
                                     ? ent_hi.val[c] : ent_lo.val[c];
                     end
                     done_ff <= 1'b1;
                  end else if (ctl.mode == MODE_CUBIC) begin
                     state_ff <= B_SETUP;
                  end else begin
                     state_ff <= B_LINEAR;
                  end
               end
            end
            B_SETUP: begin
               if (phase_ff) begin
                  if (!op_ff[0]) begin
                     s2_ff <= prod_ff[32:16];
                     op_ff <= 3'd1;
                  end else begin
                     s3_ff    <= prod_ff[32:16];
                     op_ff    <= 3'd0;
                     state_ff <= B_CUBIC;
                  end
               end
            end
            B_CUBIC: begin
               if (phase_ff) begin
                  op_ff <= op_ff + 3'd1;
                  unique case (op_ff)
                     3'd0:    m0_ff <= prod_ff[PROD_W-3:16];
                     3'd1:    m1_ff <= prod_ff[PROD_W-3:16];
                     default: acc_ff <= acc_sum;
                  endcase
                  if (op_ff == 3'd7) begin
                     res_ff[comp_ff] <= sat_value(acc_sum >>> 16);
                     if (comp_ff == 2'(COMP_N - 1)) begin
                        state_ff <= B_IDLE;
                        done_ff  <= 1'b1;
                     end else begin
                        comp_ff <= comp_ff + 2'd1;
                     end
                  end
               end
            end
            B_LINEAR: begin
               if (phase_ff) begin
                  res_ff[comp_ff] <= sat_value(lin_sum);
                  if (comp_ff == 2'(COMP_N - 1)) begin
                     state_ff <= B_IDLE;
                     done_ff  <= 1'b1;
                  end else begin
                     comp_ff <= comp_ff + 2'd1;
                  end
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of keyframe_vec3_interpolator_core: random keyframe tables
// and queries, an in-order predictor of the sampled vector, and a response scoreboard.
// Depends on kvi_pkg and the core RTL only.
module tb_top;

   typedef struct {
      logic             func;
      logic [7:0]       slot;
      logic [31:0]      tp;
      logic [2:0][31:0] itan;
      logic [2:0][31:0] val;
      logic [2:0][31:0] otan;
   } key_req_type;

   typedef struct {
      logic [2:0][31:0] vec;
      logic             fb;
   } sample_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [327:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [kvi_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [kvi_pkg::DATA_W-1:0]    csr_data = '0;

   key_req_type pending_q[$];
   sample_type  sample_q[$];
   key_req_type cur_req;
   bit          steady = 0;
   int          n_items = 0;
   int          n_errors = 0;

   // Predicted state of the block.
   logic [1:0]         cur_mode = kvi_pkg::MODE_LINEAR;
   int unsigned        cur_count = 0;
   logic [2:0][31:0]   cur_fb = '0;
   logic [31:0]        tbl_time[256];
   logic signed [31:0] tbl_in[256][3];
   logic signed [31:0] tbl_val[256][3];
   logic signed [31:0] tbl_out[256][3];

   // Times as the stimulus generator laid them out.
   logic [31:0] plan_t[256];

   always #5 clock = ~clock;

   keyframe_vec3_interpolator_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic int unsigned first_not_below(int unsigned n, logic [31:0] t);
      int unsigned first;
      int unsigned len;
      int unsigned half;
      first = 0;
      len = n;
      while (len > 0) begin
         half = len / 2;
         if (tbl_time[first + half] < t) begin
            first += half + 1;
            len -= half + 1;
         end else begin
            len = half;
         end
      end
      return first;
   endfunction

   function automatic sample_type sample_track(logic [31:0] t);
      sample_type e;
      int unsigned n, lo, hi, k;
      longint unsigned alpha, dt, diff;
      longint s, s2, s3, h00, h10, h01, h11, p0, p1, m0, m1, r;
      alpha = 0;
      dt = 0;
      n = (cur_count > 256) ? 256 : cur_count;
      if (n == 0) begin
         e.vec = cur_fb;
         e.fb = 1'b1;
         return e;
      end
      if (n == 1 || t <= tbl_time[0]) begin
         lo = 0;
         hi = 0;
      end else if (t >= tbl_time[n-1]) begin
         lo = n - 1;
         hi = n - 1;
      end else begin
         hi = first_not_below(n, t);
         if (hi < 1) hi = 1;
         if (hi > n - 1) hi = n - 1;
         lo = hi - 1;
         if (tbl_time[hi] > tbl_time[lo]) begin
            dt = longint'(tbl_time[hi]) - longint'(tbl_time[lo]);
            if (t > tbl_time[lo]) begin
               diff = longint'(t) - longint'(tbl_time[lo]);
               alpha = (diff >= dt) ? 65536 : (diff << 16) / dt;
            end
         end
      end
      for (int c = 0; c < 3; c++) begin
         if (cur_mode == kvi_pkg::MODE_STEP) begin
            k = (alpha >= 65536) ? hi : lo;
            r = tbl_val[k][c];
         end else if (lo == hi) begin
            r = tbl_val[lo][c];
         end else if (cur_mode == kvi_pkg::MODE_CUBIC) begin
            s = alpha;
            s2 = (s * s) >>> 16;
            s3 = (s2 * s) >>> 16;
            h00 = 2 * s3 - 3 * s2 + 65536;
            h10 = s3 - 2 * s2 + s;
            h01 = -2 * s3 + 3 * s2;
            h11 = s3 - s2;
            p0 = tbl_val[lo][c];
            p1 = tbl_val[hi][c];
            m0 = (longint'(tbl_out[lo][c]) * longint'(dt)) >>> 16;
            m1 = (longint'(tbl_in[hi][c]) * longint'(dt)) >>> 16;
            r = (h00 * p0 + h10 * m0 + h01 * p1 + h11 * m1) >>> 16;
         end else begin
            // Linear; the undefined mode behaves the same way.
            p0 = tbl_val[lo][c];
            p1 = tbl_val[hi][c];
            r = p0 + (((p1 - p0) * longint'(alpha)) >>> 16);
         end
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         else if (r < -64'sd2147483648) r = -64'sd2147483648;
         e.vec[c] = r[31:0];
      end
      e.fb = 1'b0;
      return e;
   endfunction

   // Driver: keeps a request steady while stalled, otherwise idles at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (cur_req.func == kvi_pkg::FUNC_WRITE) begin
               tbl_time[cur_req.slot] = cur_req.tp;
               for (int c = 0; c < 3; c++) begin
                  tbl_in[cur_req.slot][c] = cur_req.itan[c];
                  tbl_val[cur_req.slot][c] = cur_req.val[c];
                  tbl_out[cur_req.slot][c] = cur_req.otan[c];
               end
            end else begin
               sample_q.push_back(sample_track(cur_req.tp));
            end
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_q.size() > 0 && (steady || $urandom_range(99) >= 25)) begin
               cur_req = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_req.func;
               req_tdata <= {cur_req.otan, cur_req.val, cur_req.itan, cur_req.tp, cur_req.slot};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure and in-order comparison.
   always @(posedge clock) begin
      sample_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 25);
         if (rsp_tvalid && rsp_tready) begin
            if (sample_q.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("ERROR: unexpected response %h fb=%b", rsp_tdata, rsp_tuser);
            end else begin
               e = sample_q.pop_front();
               if (rsp_tdata != {e.vec[2], e.vec[1], e.vec[0]} || rsp_tuser != e.fb) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("ERROR: response z/y/x %h fb=%b, expected %h fb=%b",
                              rsp_tdata, rsp_tuser, {e.vec[2], e.vec[1], e.vec[0]}, e.fb);
               end
            end
         end
      end
   end

   function automatic logic [31:0] rand_q();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom_range(0, 32'h40000) - 32'h20000;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_write(int slot, logic [31:0] t);
      key_req_type it;
      it.func = kvi_pkg::FUNC_WRITE;
      it.slot = 8'(slot);
      it.tp = t;
      for (int c = 0; c < 3; c++) begin
         it.itan[c] = rand_q();
         it.val[c] = rand_q();
         it.otan[c] = rand_q();
      end
      plan_t[slot] = t;
      pending_q.push_back(it);
      n_items++;
   endtask

   task automatic push_query(logic [31:0] t);
      key_req_type it;
      it.func = kvi_pkg::FUNC_QUERY;
      it.tp = t;
      // Query requests carry random filler in the entry fields.
      it.slot = 8'($urandom);
      for (int c = 0; c < 3; c++) begin
         it.itan[c] = $urandom;
         it.val[c] = $urandom;
         it.otan[c] = $urandom;
      end
      pending_q.push_back(it);
      n_items++;
   endtask

   function automatic logic [31:0] pick_time(int n);
      logic [31:0] kt;
      longint lo_t, hi_t;
      if (n == 0) return $urandom;
      kt = plan_t[$urandom_range(0, n - 1)];
      lo_t = plan_t[0];
      hi_t = plan_t[n - 1];
      case ($urandom_range(7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return kt;
         3: return kt + 1;
         4: return kt - 1;
         5: return $urandom;
         default: begin
            if (hi_t > lo_t) return 32'(lo_t + ({$urandom, $urandom} % (hi_t - lo_t + 1)));
            return kt;
         end
      endcase
   endfunction

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_tvalid || sample_q.size() != 0)
         @(posedge clock);
      // A trailing entry write gives no response; let it settle.
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(logic [kvi_pkg::CSR_IDX_W-1:0] idx, logic [31:0] d);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         kvi_pkg::CSR_MODE:      cur_mode = d[1:0];
         kvi_pkg::CSR_KEY_COUNT: cur_count = d[8:0];
         kvi_pkg::CSR_FB_X:      cur_fb[0] = d;
         kvi_pkg::CSR_FB_Y:      cur_fb[1] = d;
         kvi_pkg::CSR_FB_Z:      cur_fb[2] = d;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // kind 0: ascending times, 1: arbitrary order, 2: full 32-bit span over two keys
   task automatic run_phase(logic [1:0] mode, int n, logic [31:0] fx, logic [31:0] fy,
                            logic [31:0] fz, int nq, int kind);
      longint t;
      int slot;
      wait_idle();
      csr_write(kvi_pkg::CSR_MODE, mode);
      csr_write(kvi_pkg::CSR_KEY_COUNT, n);
      csr_write(kvi_pkg::CSR_FB_X, fx);
      csr_write(kvi_pkg::CSR_FB_Y, fy);
      csr_write(kvi_pkg::CSR_FB_Z, fz);
      @(negedge clock);
      t = $urandom_range(0, 32'h20000);
      for (int i = 0; i < n; i++) begin
         if (kind == 1) begin
            push_write(i, $urandom);
         end else if (kind == 2) begin
            push_write(i, (i == 0) ? 32'h0 : 32'hFFFF_FFFF);
         end else begin
            push_write(i, 32'(t));
            case ($urandom_range(3))
               0: t += $urandom_range(1, 16);
               1: t += $urandom_range(1, 32'h40000);
               2: t += $urandom_range(0, 2);
               default: t += $urandom;
            endcase
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
         end
      end
      if (n < 256 && $urandom_range(1)) push_write($urandom_range(n, 255), $urandom);
      push_query(32'h0);
      push_query(32'hFFFF_FFFF);
      for (int q = 0; q < nq; q++) begin
         if ($urandom_range(11) == 0) begin
            // Rewrite an entry mid-stream; this may unsort the table.
            slot = $urandom_range(0, 255);
            if (slot < n || plan_t[slot] !== 32'hx) push_write(slot, $urandom);
         end
         push_query(pick_time(n));
      end
   endtask

   initial begin
      int ph;
      int n;
      int r;
      for (int i = 0; i < 256; i++) plan_t[i] = 32'hx;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // Empty table straight out of reset.
      @(negedge clock);
      push_query(32'h0);
      push_query(32'hFFFF_FFFF);
      run_phase(kvi_pkg::MODE_LINEAR, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 2, 0);
      run_phase(kvi_pkg::MODE_STEP, 1, 0, 0, 0, 3, 0);
      run_phase(kvi_pkg::MODE_STEP, 2, 0, 0, 0, 4, 0);
      run_phase(kvi_pkg::MODE_LINEAR, 2, 0, 0, 0, 4, 2);
      run_phase(kvi_pkg::MODE_CUBIC, 2, 0, 0, 0, 4, 2);
      run_phase(2'd3, 3, 0, 0, 0, 3, 0);
      ph = 0;
      while (n_items < 1400) begin
         steady = (ph >= 8 && ph < 12);
         r = $urandom_range(19);
         if (r == 0) n = 0;
         else if (r == 1) n = 256;
         else if (r < 6) n = $urandom_range(9, 64);
         else n = $urandom_range(1, 8);
         r = $urandom_range(9);
         run_phase(2'($urandom_range(0, 3)), n, rand_q(), rand_q(), rand_q(),
                   $urandom_range(20, 60), (r == 0) ? 1 : (r == 1 && n >= 2) ? 2 : 0);
         ph++;
      end
      steady = 0;
      wait_idle();
      if (n_errors == 0 && sample_q.size() == 0)
         $display("PASS keyframe_vec3_interpolator_core");
      else
         $display("FAIL keyframe_vec3_interpolator_core");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL keyframe_vec3_interpolator_core");
      $finish;
   end

endmodule
